/* rtl/qaps_pkg.sv */
// Shared types, constants and helpers for the quote-aware pattern search.
// No dependencies; imported by every module of the block.
package qaps_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BTICK  = 8'h60;

  // Configuration register indexes
  localparam logic REG_PATTERN_CHARS = 1'b0;
  localparam logic REG_PATTERN_LEN   = 1'b1;

  localparam int CFG_DATA_BITS = 64;

  // Depth of the queue between classifier and matcher
  localparam int QUEUE_DEPTH = 4;

  // One classified byte on its way to the matcher
  typedef struct packed {
    logic [7:0] ch;
    logic       elig;
    logic       last;
  } qaps_item_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

endpackage

/* rtl/qaps_front.sv */
// Front end: accepts text bytes and tracks quote and escape state.
// Marks each byte that may start a match; uses qaps_pkg.
module qaps_front
  import qaps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] ch,
  input  logic       last,
  input  logic       q_full,
  output logic       push,
  output qaps_item_t item
);

  logic [7:0] open_quote;
  logic [7:0] open_quote_next;
  logic       escape_pending;
  logic       escape_pending_next;
  logic       elig;

  assign push = in_valid && !q_full;

  always_comb begin
    open_quote_next     = open_quote;
    escape_pending_next = escape_pending;
    elig                = 1'b0;
    if (ch == open_quote) begin
      if (escape_pending) begin
        escape_pending_next = 1'b0;
      end else begin
        open_quote_next = 8'h00;
      end
    end else if (open_quote != 8'h00) begin
      escape_pending_next = !escape_pending && (ch == CH_BSLASH);
    end else if (ch == CH_DQUOTE || ch == CH_SQUOTE || ch == CH_BTICK) begin
      open_quote_next = ch;
    end else begin
      elig = 1'b1;
    end
    // end of string: drop quote state
    if (last) begin
      open_quote_next     = 8'h00;
      escape_pending_next = 1'b0;
    end
  end

  assign item = '{ch: ch, elig: elig, last: last};

  always_ff @(posedge clk) begin
    if (rst) begin
      open_quote     <= 8'h00;
      escape_pending <= 1'b0;
    end else if (push) begin
      open_quote     <= open_quote_next;
      escape_pending <= escape_pending_next;
    end
  end

endmodule

/* rtl/qaps_queue.sv */
// Short queue of classified bytes between front end and matcher.
// Depth from qaps_pkg::QUEUE_DEPTH; uses qaps_pkg.
module qaps_queue
  import qaps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  qaps_item_t push_item,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output qaps_item_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qaps_item_t       entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/qaps_back.sv */
// Matcher: byte window, start marks, position count and result register.
// Holds the pattern registers; uses qaps_pkg.
module qaps_back
  import qaps_pkg::*;
#(
  parameter int MAX_PATTERN   = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     q_valid,
  input  qaps_item_t               q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     found,
  output logic [15:0]              position
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_W = POSITION_BITS + 1;
  localparam logic [CNT_W-1:0] POS_LIMIT = {1'b0, {POSITION_BITS{1'b1}}};
  localparam logic [CNT_W-1:0] IDX_LIMIT = POS_LIMIT + CNT_W'(MAX_PATTERN);

  logic [MAX_PATTERN-1:0][7:0] pattern;
  logic [IDX_W-1:0]            len_m1;

  logic [7:0]             win [MAX_PATTERN];
  logic [7:0]             win_next [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] start_eligible;
  logic [MAX_PATTERN-1:0] start_eligible_next;
  logic [CNT_W-1:0]       byte_count;
  logic [CNT_W-1:0]       byte_count_next;
  logic                   match_done;

  logic                   hit;
  logic                   res_valid;
  logic                   res_found;
  logic [CNT_W-1:0]       start_idx;
  logic [CNT_W-1:0]       res_pos;
  logic [CNT_W+15:0]      res_pos_ext;
  logic [IDX_W-1:0]       pidx;

  // Configuration: clamp length once, at write time
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0;
      len_m1  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_CHARS: pattern <= cfg_data[8*MAX_PATTERN-1:0];
        REG_PATTERN_LEN: begin
          if (cfg_data[3:0] == 4'd0) begin
            len_m1 <= '0;
          end else if (cfg_data[3:0] > 4'(MAX_PATTERN)) begin
            len_m1 <= IDX_W'(MAX_PATTERN - 1);
          end else begin
            len_m1 <= IDX_W'(cfg_data[3:0] - 4'd1);
          end
        end
        default: ;
      endcase
    end
  end

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    win_next[0]            = q_item.ch;
    start_eligible_next[0] = q_item.elig;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_next[k]            = win[k-1];
      start_eligible_next[k] = start_eligible[k-1];
    end
  end

  // Lane j of the window meets pattern byte len_m1 - j
  always_comb begin
    hit = start_eligible_next[len_m1];
    pidx = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pidx = len_m1 - IDX_W'(j);
      if (IDX_W'(j) <= len_m1) begin
        if (fold_case(win_next[j]) != fold_case(pattern[pidx])) begin
          hit = 1'b0;
        end
      end
    end
  end

  always_comb begin
    byte_count_next = (byte_count < IDX_LIMIT) ? byte_count + 1'b1 : byte_count;
    start_idx       = byte_count - CNT_W'(len_m1);
    res_valid       = 1'b0;
    res_found       = 1'b0;
    res_pos         = '0;
    if (!match_done) begin
      if (hit) begin
        res_valid = 1'b1;
        res_found = 1'b1;
        res_pos   = (start_idx > POS_LIMIT) ? POS_LIMIT : start_idx;
      end else if (q_item.last) begin
        res_valid = 1'b1;
        res_pos   = (byte_count_next > POS_LIMIT) ? POS_LIMIT : byte_count_next;
      end
    end
    res_pos_ext = {16'h0000, res_pos};
  end

  always_ff @(posedge clk) begin
    if (q_pop && !match_done && !q_item.last) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win[k] <= win_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_eligible <= '0;
      byte_count     <= '0;
      match_done     <= 1'b0;
    end else if (q_pop) begin
      if (q_item.last) begin
        start_eligible <= '0;
        byte_count     <= '0;
        match_done     <= 1'b0;
      end else if (!match_done) begin
        start_eligible <= start_eligible_next;
        byte_count     <= byte_count_next;
        match_done     <= hit;
      end
    end
  end

  // Result register: parts matcher from the output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      found    <= res_found;
      position <= res_pos_ext[15:0];
    end
  end

endmodule

/* rtl/quote_aware_pattern_search.sv */
// Top level of the quote-aware, case-insensitive pattern search.
// Joins qaps_front, qaps_queue and qaps_back; uses qaps_pkg.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  in      | in_valid / in_ready  | ch[7:0], last
//  out     | out_valid / out_ready| found, position[15:0]
//  cfg     | cfg_we               | cfg_index, cfg_data[63:0]
//
// One byte per cycle sustained while the output is not stalled; a result is
// registered after its byte's transfer (queue slot, then the result register).
// Rate is set by the combinational window compare in the matcher.
// Reset clears quote state, queue, window marks and the result valid flag.
// A stalled output fills the queue; in_ready drops when the queue is full.
module quote_aware_pattern_search
  import qaps_pkg::*;
#(
  parameter int MAX_PATTERN   = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               ch,
  input  logic                     last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     found,
  output logic [15:0]              position,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic       push;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  qaps_item_t push_item;
  qaps_item_t q_item;

  assign in_ready = !q_full;

  qaps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .ch       (ch),
    .last     (last),
    .q_full   (q_full),
    .push     (push),
    .item     (push_item)
  );

  qaps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_item)
  );

  qaps_back #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .position  (position)
  );

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> q_valid)
    else $error("accepted byte missing from queue");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("queue full and empty at once");

  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_valid && (!out_valid || out_ready)))
    else $error("matcher advanced without room for a result");

endmodule
